// File: rtl/json_string_unescaper_defines.svh
// ---------------------------------------------------------------------------
// json_string_unescaper_defines.svh
// Assertion macros used by the json_string_unescaper RTL.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_DEFINES_SVH
`define JSON_STRING_UNESCAPER_DEFINES_SVH

// Implication checked every cycle outside reset.
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in every cycle outside reset.
`define JSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg
// Types, character constants and helpers for the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_PRE  = 6'b000001,
    PH_BODY = 6'b000010,
    PH_ESC  = 6'b000100,
    PH_HEX  = 6'b001000,
    PH_POST = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_e;

  // Status codes reported on the end word
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FRAME  = 3'd1,
    ST_ESCAPE = 3'd2,
    ST_FORBID = 3'd3,
    ST_HEX    = 3'd4
  } status_e;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SOLIDUS = 8'h2F;
  localparam logic [7:0] CH_CTL_MAX = 8'h1F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_LC_B    = 8'h62;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_LC_N    = 8'h6E;
  localparam logic [7:0] CH_LC_R    = 8'h72;
  localparam logic [7:0] CH_LC_T    = 8'h74;
  localparam logic [7:0] CH_LC_U    = 8'h75;

  // Marker for a byte that is not a hex digit
  localparam logic [4:0] NIB_BAD = 5'd16;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] hex_cnt;
    logic [7:0] hex_low;
    status_e    err;
  } jsu_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    status_e    status;
  } jsu_res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_allowed(input logic [7:0] c);
    return (c != CH_QUOTE) && (c != CH_BSLASH) && (c > CH_CTL_MAX);
  endfunction

  // Nibble value 0..15, or NIB_BAD for a non-hex byte
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = {3'd0, NIB_BAD};
    end
    return v[4:0];
  endfunction

endpackage

// File: rtl/jsu_in_if.sv
// ---------------------------------------------------------------------------
// jsu_in_if
// Raw document byte channel: valid/ready with byte and last flag.
// ---------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/jsu_out_if.sv
// ---------------------------------------------------------------------------
// jsu_out_if
// Decoded byte channel: valid/ready with byte, end flag and status.
// ---------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  logic [2:0] out_status;

  modport source (output valid, output out_byte, output out_end, output out_status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_end, input out_status,
                  output ready);
endinterface

// File: rtl/jsu_decode.sv
// ---------------------------------------------------------------------------
// jsu_decode
// Next-state and result logic for one document byte.
// ---------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::jsu_state_t cur_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output jsu_pkg::jsu_state_t nxt_o,
  output jsu_pkg::jsu_res_t   res_o
);
  import jsu_pkg::*;

  always_comb begin
    jsu_state_t nxt;
    logic       emit;
    logic [7:0] ob;
    logic       do_fail;
    status_e    fail_code;
    logic [4:0] nib;
    logic [7:0] hl;

    nxt       = cur_i;
    emit      = 1'b0;
    ob        = 8'd0;
    do_fail   = 1'b0;
    fail_code = ST_OK;
    nib       = hex_val(byte_i);
    hl        = {cur_i.hex_low[3:0], nib[3:0]};

    // phase machine
    unique case (cur_i.phase)
      PH_PRE: begin
        if (byte_i == CH_QUOTE) begin
          nxt.phase = PH_BODY;
        end else if (!is_ws(byte_i)) begin
          do_fail = 1'b1; fail_code = ST_FRAME;
        end
      end
      PH_BODY: begin
        if (byte_i == CH_QUOTE) begin
          nxt.phase = PH_POST;
        end else if (byte_i == CH_BSLASH) begin
          nxt.phase = PH_ESC;
        end else if (byte_i <= CH_CTL_MAX) begin
          do_fail = 1'b1; fail_code = ST_FORBID;
        end else begin
          emit = 1'b1; ob = byte_i;
        end
      end
      PH_ESC: begin
        nxt.phase = PH_BODY;
        emit      = 1'b1;
        case (byte_i)
          CH_QUOTE, CH_BSLASH, CH_SOLIDUS: ob = byte_i;
          CH_LC_B: ob = CH_BS;
          CH_LC_F: ob = CH_FF;
          CH_LC_N: ob = CH_LF;
          CH_LC_R: ob = CH_CR;
          CH_LC_T: ob = CH_TAB;
          CH_LC_U: begin
            emit        = 1'b0;
            nxt.phase   = PH_HEX;
            nxt.hex_cnt = 2'd0;
            nxt.hex_low = 8'd0;
          end
          default: begin
            emit = 1'b0; do_fail = 1'b1; fail_code = ST_ESCAPE;
          end
        endcase
      end
      PH_HEX: begin
        if (nib == NIB_BAD) begin
          do_fail = 1'b1; fail_code = ST_HEX;
        end else begin
          nxt.hex_low = hl;
          if (cur_i.hex_cnt == 2'd3) begin
            nxt.hex_cnt = 2'd0;
            nxt.phase   = PH_BODY;
            if (!is_allowed(hl)) begin
              do_fail = 1'b1; fail_code = ST_FORBID;
            end else begin
              emit = 1'b1; ob = hl;
            end
          end else begin
            nxt.hex_cnt = cur_i.hex_cnt + 2'd1;
          end
        end
      end
      PH_POST: begin
        if (!is_ws(byte_i)) begin
          do_fail = 1'b1; fail_code = ST_FRAME;
        end
      end
      PH_ERR: begin
        nxt.phase = PH_ERR;
      end
      default: begin
        nxt.phase = PH_ERR;
      end
    endcase

    // first error latches
    if (do_fail) begin
      if (nxt.err == ST_OK) nxt.err = fail_code;
      nxt.phase = PH_ERR;
    end

    // end word or data word
    res_o = '{valid: 1'b0, data: 8'd0, last: 1'b0, status: ST_OK};
    if (last_i) begin
      res_o.valid  = 1'b1;
      res_o.last   = 1'b1;
      res_o.status = (nxt.err == ST_OK && nxt.phase != PH_POST) ? ST_FRAME : nxt.err;
      nxt = '{phase: PH_PRE, hex_cnt: 2'd0, hex_low: 8'd0, err: ST_OK};
    end else if (emit && nxt.err == ST_OK) begin
      res_o.valid = 1'b1;
      res_o.data  = ob;
    end
    nxt_o = nxt;
  end

endmodule

// File: rtl/json_string_unescaper.sv
// An accepted byte passes the input register, then the output register.
// Throughput: one byte per cycle unless a byte with a word meets a full,
// stalled output slot; the input and output registers decouple the sides,
// so bytes that yield no word keep flowing while a word waits. The phase machine in jsu_decode is combinational.
// Reset (rst_ni low, asynchronous): both channels empty, phase before the
// opening quote, no error latched.
// ---------------------------------------------------------------------------
// json_string_unescaper
// Streaming unescaper for one quoted JSON string per document.
// ---------------------------------------------------------------------------
`include "json_string_unescaper_defines.svh"

module json_string_unescaper (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // parse state
  jsu_state_t st_q, st_d;
  jsu_res_t   res;

  // output register
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_end_q;
  status_e    out_status_q;

  logic adv;

  jsu_decode u_decode (
    .cur_i  (st_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .nxt_o  (st_d),
    .res_o  (res)
  );

  // a held byte moves on unless it has a word and the output slot is full and not being drained
  assign adv        = in_vld_q && (!res.valid || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.in_last;
    end
  end

  // parse state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_PRE, hex_cnt: 2'd0, hex_low: 8'd0, err: ST_OK};
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && res.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_byte_q   <= res.data;
      out_end_q    <= res.last;
      out_status_q <= res.status;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.out_end    = out_end_q;
  assign out_o.out_status = out_status_q;

  // checks
  `JSU_ASSERT_IMP(a_err_parks, st_q.err != ST_OK, st_q.phase == PH_ERR,
                  "error latched outside error phase")
  `JSU_ASSERT_IMP(a_data_ok, out_vld_q && !out_end_q, out_status_q == ST_OK,
                  "data word with nonzero status")
  `JSU_ASSERT_IMP(a_hex_cnt, st_q.hex_cnt != 2'd0,
                  st_q.phase == PH_HEX || st_q.phase == PH_ERR,
                  "hex count live outside hex phase")
  `JSU_ASSERT_IMP(a_no_overrun, out_vld_q && !out_o.ready && adv, !res.valid,
                  "word would overwrite a stalled output")

endmodule
